// File: hdl/vitr_pkg.sv
// vitr_pkg: shared types and codes for the interface timer register block.
// Holds the command and register codes, flag bit positions and word structs.
// No dependencies.
package vitr_pkg;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Register numbers in standard order
    localparam logic [3:0] REG_PORT_B    = 4'd0;
    localparam logic [3:0] REG_PORT_A    = 4'd1;
    localparam logic [3:0] REG_DDR_B     = 4'd2;
    localparam logic [3:0] REG_DDR_A     = 4'd3;
    localparam logic [3:0] REG_T1C_LO    = 4'd4;
    localparam logic [3:0] REG_T1C_HI    = 4'd5;
    localparam logic [3:0] REG_T1L_LO    = 4'd6;
    localparam logic [3:0] REG_T1L_HI    = 4'd7;
    localparam logic [3:0] REG_T2C_LO    = 4'd8;
    localparam logic [3:0] REG_T2C_HI    = 4'd9;
    localparam logic [3:0] REG_SR        = 4'd10;
    localparam logic [3:0] REG_ACR       = 4'd11;
    localparam logic [3:0] REG_PCR       = 4'd12;
    localparam logic [3:0] REG_IFR       = 4'd13;
    localparam logic [3:0] REG_IER       = 4'd14;
    localparam logic [3:0] REG_PORT_A_NH = 4'd15;

    // Flag layout
    localparam int FLAG_W      = 7;
    localparam int FLAG_T1_BIT = 6;
    localparam int FLAG_T2_BIT = 5;
    localparam int ACR_CONT_BIT = 6;
    localparam int IER_SET_BIT  = 7;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] reg_sel;
        logic [7:0] wdata;
    } req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_out;
    } rsp_t;

endpackage

// File: hdl/vitr_core.sv
// vitr_core: register file, flag logic and the two down timers.
// Applies one request word per step and returns its response word.
// Depends on vitr_pkg.
module vitr_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  vitr_pkg::req_t req,
    output vitr_pkg::rsp_t rsp
);

    logic [7:0]  port_a_reg, port_a_next;
    logic [7:0]  port_b_reg, port_b_next;
    logic [7:0]  dir_a_reg, dir_a_next;
    logic [7:0]  dir_b_reg, dir_b_next;
    logic [15:0] t1_count_reg, t1_count_next;
    logic [15:0] t1_latch_reg, t1_latch_next;
    logic [15:0] t2_count_reg, t2_count_next;
    logic [7:0]  t2_low_reg, t2_low_next;
    logic [7:0]  sr_data_reg, sr_data_next;
    logic [7:0]  acr_reg, acr_next;
    logic [7:0]  pcr_reg, pcr_next;
    logic [vitr_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic [vitr_pkg::FLAG_W-1:0] enables_reg, enables_next;
    logic        t1_run_reg, t1_run_next;
    logic        t2_run_reg, t2_run_next;

    logic [7:0]  rdata;
    logic        irq_now;

    assign irq_now = |(flags_reg & enables_reg);

    // Work out the next state and the read byte for the current request
    always_comb
    begin
        port_a_next  = port_a_reg;
        port_b_next  = port_b_reg;
        dir_a_next   = dir_a_reg;
        dir_b_next   = dir_b_reg;
        t1_count_next = t1_count_reg;
        t1_latch_next = t1_latch_reg;
        t2_count_next = t2_count_reg;
        t2_low_next  = t2_low_reg;
        sr_data_next = sr_data_reg;
        acr_next     = acr_reg;
        pcr_next     = pcr_reg;
        flags_next   = flags_reg;
        enables_next = enables_reg;
        t1_run_next  = t1_run_reg;
        t2_run_next  = t2_run_reg;
        rdata        = 8'h00;

        case (req.cmd)
            vitr_pkg::CMD_READ:
            begin
                unique case (req.reg_sel) inside
                    vitr_pkg::REG_PORT_B: rdata = port_b_reg;
                    vitr_pkg::REG_PORT_A, vitr_pkg::REG_PORT_A_NH: rdata = port_a_reg;
                    vitr_pkg::REG_DDR_B:  rdata = dir_b_reg;
                    vitr_pkg::REG_DDR_A:  rdata = dir_a_reg;
                    vitr_pkg::REG_T1C_LO:
                    begin
                        rdata = t1_count_reg[7:0];
                        flags_next[vitr_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    vitr_pkg::REG_T1C_HI: rdata = t1_count_reg[15:8];
                    vitr_pkg::REG_T1L_LO: rdata = t1_latch_reg[7:0];
                    vitr_pkg::REG_T1L_HI: rdata = t1_latch_reg[15:8];
                    vitr_pkg::REG_T2C_LO:
                    begin
                        rdata = t2_count_reg[7:0];
                        flags_next[vitr_pkg::FLAG_T2_BIT] = 1'b0;
                    end
                    vitr_pkg::REG_T2C_HI: rdata = t2_count_reg[15:8];
                    vitr_pkg::REG_SR:     rdata = sr_data_reg;
                    vitr_pkg::REG_ACR:    rdata = acr_reg;
                    vitr_pkg::REG_PCR:    rdata = pcr_reg;
                    vitr_pkg::REG_IFR:    rdata = {irq_now, flags_reg};
                    default:              rdata = {1'b1, enables_reg};
                endcase
            end
            vitr_pkg::CMD_WRITE:
            begin
                unique case (req.reg_sel) inside
                    vitr_pkg::REG_PORT_B: port_b_next = req.wdata;
                    vitr_pkg::REG_PORT_A, vitr_pkg::REG_PORT_A_NH: port_a_next = req.wdata;
                    vitr_pkg::REG_DDR_B:  dir_b_next = req.wdata;
                    vitr_pkg::REG_DDR_A:  dir_a_next = req.wdata;
                    vitr_pkg::REG_T1C_LO, vitr_pkg::REG_T1L_LO:
                        t1_latch_next = {t1_latch_reg[15:8], req.wdata};
                    vitr_pkg::REG_T1C_HI:
                    begin
                        // load latch high, copy latch into counter and start
                        t1_latch_next = {req.wdata, t1_latch_reg[7:0]};
                        t1_count_next = {req.wdata, t1_latch_reg[7:0]};
                        t1_run_next   = 1'b1;
                        flags_next[vitr_pkg::FLAG_T1_BIT] = 1'b0;
                    end
                    vitr_pkg::REG_T1L_HI:
                        t1_latch_next = {req.wdata, t1_latch_reg[7:0]};
                    vitr_pkg::REG_T2C_LO: t2_low_next = req.wdata;
                    vitr_pkg::REG_T2C_HI:
                    begin
                        t2_count_next = {req.wdata, t2_low_reg};
                        t2_run_next   = 1'b1;
                        flags_next[vitr_pkg::FLAG_T2_BIT] = 1'b0;
                    end
                    vitr_pkg::REG_SR:     sr_data_next = req.wdata;
                    vitr_pkg::REG_ACR:    acr_next = req.wdata;
                    vitr_pkg::REG_PCR:    pcr_next = req.wdata;
                    vitr_pkg::REG_IFR:
                        flags_next = flags_reg & ~req.wdata[vitr_pkg::FLAG_W-1:0];
                    default:
                    begin
                        // bit 7 picks set or clear of the enables named
                        if (req.wdata[vitr_pkg::IER_SET_BIT])
                            enables_next = enables_reg | req.wdata[vitr_pkg::FLAG_W-1:0];
                        else
                            enables_next = enables_reg & ~req.wdata[vitr_pkg::FLAG_W-1:0];
                    end
                endcase
            end
            vitr_pkg::CMD_TICK:
            begin
                // timer 1: flag at zero, then reload or stop
                if (t1_run_reg)
                begin
                    if (t1_count_reg == 16'h0000)
                    begin
                        flags_next[vitr_pkg::FLAG_T1_BIT] = 1'b1;
                        if (acr_reg[vitr_pkg::ACR_CONT_BIT])
                            t1_count_next = t1_latch_reg;
                        else
                            t1_run_next = 1'b0;
                    end
                    else
                        t1_count_next = t1_count_reg - 16'd1;
                end
                // timer 2: flag at zero and stop
                if (t2_run_reg)
                begin
                    if (t2_count_reg == 16'h0000)
                    begin
                        flags_next[vitr_pkg::FLAG_T2_BIT] = 1'b1;
                        t2_run_next = 1'b0;
                    end
                    else
                        t2_count_next = t2_count_reg - 16'd1;
                end
            end
            default:
            begin
                rdata = 8'h00;
            end
        endcase
    end

    assign rsp.rdata   = rdata;
    assign rsp.irq_out = |(flags_next & enables_next);

    // Commit the state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg   <= 8'h00;
            port_b_reg   <= 8'h00;
            dir_a_reg    <= 8'h00;
            dir_b_reg    <= 8'h00;
            t1_count_reg <= 16'hFFFF;
            t1_latch_reg <= 16'hFFFF;
            t2_count_reg <= 16'hFFFF;
            t2_low_reg   <= 8'hFF;
            sr_data_reg  <= 8'h00;
            acr_reg      <= 8'h00;
            pcr_reg      <= 8'h00;
            flags_reg    <= '0;
            enables_reg  <= '0;
            t1_run_reg   <= 1'b0;
            t2_run_reg   <= 1'b0;
        end
        else if (step)
        begin
            port_a_reg   <= port_a_next;
            port_b_reg   <= port_b_next;
            dir_a_reg    <= dir_a_next;
            dir_b_reg    <= dir_b_next;
            t1_count_reg <= t1_count_next;
            t1_latch_reg <= t1_latch_next;
            t2_count_reg <= t2_count_next;
            t2_low_reg   <= t2_low_next;
            sr_data_reg  <= sr_data_next;
            acr_reg      <= acr_next;
            pcr_reg      <= pcr_next;
            flags_reg    <= flags_next;
            enables_reg  <= enables_next;
            t1_run_reg   <= t1_run_next;
            t2_run_reg   <= t2_run_next;
        end
    end

endmodule

// File: hdl/versatile_interface_timer_regs.sv
// An accepted word waits in the input register and its response in the output register.
// Throughput: one word per cycle while rsp_stall is low; the input register, the single-pass
// register update in vitr_core and the output register each take one word a cycle.
// Reset (rst_n low, asynchronous) empties both pipeline registers and returns
// all registers, timers and flags to their power-up values.
// Depends on vitr_pkg and vitr_core.
module versatile_interface_timer_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  vitr_pkg::req_t cmd_word,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output vitr_pkg::rsp_t rsp_word
);

    logic           req_valid_reg;
    vitr_pkg::req_t req_word_reg;
    logic           out_valid_reg;
    vitr_pkg::rsp_t out_word_reg;
    vitr_pkg::rsp_t core_rsp;
    logic           advance;
    logic           take;

    // Move the held request into the result register when that one is free
    assign advance   = req_valid_reg && (!out_valid_reg || !rsp_stall);
    assign cmd_stall = req_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    // Hold the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (take || advance)
            req_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            req_word_reg <= cmd_word;
    end

    vitr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (req_word_reg),
        .rsp   (core_rsp)
    );

    // Result register; drop the word once the far side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= core_rsp;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

// File: hdl/vitr_checker.sv
// vitr_checker: port-level checks of the interface timer register block.
// Bound to versatile_interface_timer_regs; depends on vitr_pkg.
module vitr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input vitr_pkg::req_t cmd_word,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input vitr_pkg::rsp_t rsp_word
);

    // A stalled request stays offered with the same word
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
        else $error("request word changed while stalled");

    // A stalled response stays valid
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response word does not change
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_word))
        else $error("response word changed while stalled");

    // With no response waiting, the request side never stalls
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !cmd_stall)
        else $error("request stalled with empty output");

    // Every accepted request is followed by a valid response
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> ##1 rsp_valid)
        else $error("no response after accepted request");

endmodule

bind versatile_interface_timer_regs vitr_checker u_vitr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
